>>> hdl/bclm_pkg.sv
// Shared types and constants for the bounds-checked linear memory.
// No dependencies; every other file in hdl imports this package.
package bclm_pkg;

  localparam int PAGE_BITS  = 16;                 // 64 KiB pages
  localparam int CAP_PAGES  = 4;
  localparam int PAGES_W    = 3;
  localparam int ADDR_W     = 32;
  localparam int LANES      = 8;                  // byte-wide banks
  localparam int LANE_BITS  = 3;
  localparam int STORE_BITS = PAGE_BITS + $clog2(CAP_PAGES);
  localparam int ROW_BITS   = STORE_BITS - LANE_BITS;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_GROW  = 2'd2;

  // access sizes
  localparam logic [1:0] SIZE_B1 = 2'd0;
  localparam logic [1:0] SIZE_B4 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_INITIAL = 2'd0;
  localparam logic [1:0] REG_MAX     = 2'd1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  address;
    logic [1:0]         size_code;
    logic               sign_extend;
    logic [63:0]        write_data;
    logic [PAGES_W-1:0] grow_pages;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        read_data;
    logic               ok;
    logic [PAGES_W-1:0] size_pages;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic access;
    logic finish;
    logic clear_step;
  } dp_cmd_t;

  typedef struct packed {
    logic reinit;
    logic clear_last;
  } dp_status_t;

  function automatic logic [PAGES_W-1:0] clamp_pages(input logic [PAGES_W-1:0] p);
    clamp_pages = (p > PAGES_W'(CAP_PAGES)) ? PAGES_W'(CAP_PAGES) : p;
  endfunction

endpackage

>>> hdl/bclm_bank.sv
// One byte-wide bank of the linear store: one row written or read per cycle.
// Depends on bclm_pkg for the row width.
module bclm_bank
  import bclm_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [ROW_BITS-1:0] row,
  input  logic [7:0]          wdata,
  output logic [7:0]          rdata
);

  logic [7:0] mem [2**ROW_BITS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[row] <= wdata;
    end
    rdata_r <= mem[row];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/bclm_ctrl.sv
// Sequencer for the linear memory: clearing pass, access and result cycles.
// Depends on bclm_pkg for the command and status structs.
module bclm_ctrl
  import bclm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_ACCESS = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
    // a new page count restarts the clearing pass
    if (status.reinit) begin
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> hdl/bclm_dp.sv
// Datapath of the linear memory: config registers, size, bounds check,
// eight byte banks and result formatting. Depends on bclm_pkg and bclm_bank.
module bclm_dp
  import bclm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  output dp_status_t   status,
  input  in_item_t     in_item,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [2:0]   cfg_wdata,
  output logic         out_valid,
  output out_item_t    out_item
);

  logic [PAGES_W-1:0]  max_pages_r;
  logic [PAGES_W-1:0]  pages_r, pages_nxt;
  logic [ROW_BITS-1:0] clr_row_r;
  in_item_t            item_r;
  logic                ok_r, ok_nxt;
  logic                out_valid_r;
  out_item_t           out_r, out_nxt;

  logic                  reinit;
  logic [3:0]            nbytes;
  logic [ADDR_W:0]       end_addr;
  logic [ADDR_W:0]       limit_bytes;
  logic                  in_range;
  logic [PAGES_W-1:0]    grow_limit;
  logic [PAGES_W:0]      grow_sum;
  logic [LANE_BITS-1:0]  off;
  logic [ROW_BITS-1:0]   row0;
  logic [LANES-1:0][7:0] bank_rdata;

  assign reinit = cfg_we && (cfg_index == REG_INITIAL);
  assign status.reinit     = reinit;
  assign status.clear_last = cmd.clear_step && (clr_row_r == '1);

  // bounds check, never wraps past 2^32
  assign nbytes      = 4'(1) << item_r.size_code;
  assign end_addr    = {1'b0, item_r.address} + (ADDR_W + 1)'(nbytes);
  assign limit_bytes = (ADDR_W + 1)'({pages_r, {PAGE_BITS{1'b0}}});
  assign in_range    = (end_addr <= limit_bytes);

  assign grow_limit = (max_pages_r == '0) ? PAGES_W'(CAP_PAGES) : clamp_pages(max_pages_r);
  assign grow_sum   = {1'b0, pages_r} + {1'b0, item_r.grow_pages};

  assign off  = item_r.address[LANE_BITS-1:0];
  assign row0 = item_r.address[STORE_BITS-1:LANE_BITS];

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [LANE_BITS-1:0] k;
    logic                 sel;
    logic [ROW_BITS-1:0]  row_acc;
    logic                 we;
    logic [ROW_BITS-1:0]  row;
    logic [7:0]           wdata;

    // byte k of the access lands in this bank; banks below the start wrap a row
    assign k       = LANE_BITS'(b) - off;
    assign sel     = ({1'b0, k} < nbytes);
    assign row_acc = row0 + ROW_BITS'(LANE_BITS'(b) < off);
    assign we      = cmd.clear_step ||
                     (cmd.access && item_r.kind == KIND_STORE && in_range && sel);
    assign row     = cmd.clear_step ? clr_row_r : row_acc;
    assign wdata   = cmd.clear_step ? 8'h00 : item_r.write_data[8*k +: 8];

    bclm_bank u_bank (
      .clk   (clk),
      .we    (we),
      .row   (row),
      .wdata (wdata),
      .rdata (bank_rdata[b])
    );
  end

  always_comb begin
    pages_nxt = pages_r;
    ok_nxt    = ok_r;
    if (cmd.access) begin
      ok_nxt = 1'b0;
      case (item_r.kind) inside
        KIND_LOAD, KIND_STORE: ok_nxt = in_range;
        KIND_GROW: begin
          if (grow_sum <= {1'b0, grow_limit}) begin
            pages_nxt = grow_sum[PAGES_W-1:0];
            ok_nxt    = 1'b1;
          end
        end
        default: ok_nxt = 1'b0;
      endcase
    end
    if (reinit) begin
      pages_nxt = clamp_pages(cfg_wdata);
    end
  end

  // gather bytes back into access order, then extend
  always_comb begin
    logic [LANE_BITS-1:0] b;
    logic [63:0]          data;
    data = '0;
    for (int k = 0; k < LANES; k++) begin
      b = off + LANE_BITS'(k);
      if (4'(k) < nbytes) begin
        data[8*k +: 8] = bank_rdata[b];
      end
    end
    if (item_r.sign_extend && item_r.size_code == SIZE_B1 && data[7]) begin
      data[63:8] = '1;
    end
    if (item_r.sign_extend && item_r.size_code == SIZE_B4 && data[31]) begin
      data[63:32] = '1;
    end
    out_nxt.read_data  = (item_r.kind == KIND_LOAD && ok_r) ? data : '0;
    out_nxt.ok         = ok_r;
    out_nxt.size_pages = pages_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pages_r     <= '0;
      pages_r         <= PAGES_W'(1);
      clr_row_r       <= '0;
      ok_r            <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_MAX) begin
        max_pages_r <= cfg_wdata;
      end
      pages_r <= pages_nxt;
      ok_r    <= ok_nxt;
      if (reinit) begin
        clr_row_r <= '0;
      end else if (cmd.clear_step) begin
        clr_row_r <= clr_row_r + ROW_BITS'(1);
      end
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> hdl/bounds_checked_linear_memory.sv
// Bounds-checked linear byte memory: 4 pages of 64 KiB in eight byte banks,
// little-endian loads and stores of 1, 2, 4 or 8 bytes at any byte address,
// and a grow request that adds pages. An item is taken when start is high and
// busy is low; its result appears on out_item with out_valid high for exactly
// one cycle, once the item is registered, the banks are addressed and their read
// registered, and the bytes are aligned, extended and registered as the result;
// there is no way to stall it. Busy stays high after a transfer until the result
// is registered, so the block takes no new item before the last one is through.
// After reset and after each write of initial_pages the banks are zeroed one row
// per cycle over all 32768 rows, and busy stays high. Write registers only while
// no item is in flight: a write of initial_pages abandons an item in progress and
// drops a start raised in the same cycle.
// Depends on bclm_pkg, bclm_ctrl, bclm_dp and bclm_bank.
module bounds_checked_linear_memory
  import bclm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bclm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  bclm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> sim/bclm_memory_check.sv
`timescale 1ns / 1ps
// Shadow model and result checker for the bounds-checked linear memory.
// Depends on bclm_pkg; watches the item, result and register ports of the block.
module bclm_memory_check
  import bclm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_wdata,
  output int         fail_count,
  output int         outstanding
);

  logic [7:0]  shadow_bytes [int unsigned];
  int unsigned shadow_pages;
  int unsigned shadow_max;
  out_item_t   pending_results [$];

  // Reload the page count and wipe the store, as a write of initial_pages does.
  function automatic void reload_pages(input int unsigned pages);
    shadow_bytes.delete();
    shadow_pages = (pages > CAP_PAGES) ? CAP_PAGES : pages;
  endfunction

  function automatic logic [7:0] byte_at(input int unsigned addr);
    return shadow_bytes.exists(addr) ? shadow_bytes[addr] : 8'h00;
  endfunction

  function automatic out_item_t predict_access(input in_item_t it);
    out_item_t   res;
    int unsigned n_bytes;
    int unsigned page_cap;
    logic [32:0] end_excl;
    logic [32:0] mem_bytes;
    logic        fits;
    res       = '0;
    n_bytes   = 1 << it.size_code;
    end_excl  = {1'b0, it.address} + 33'(n_bytes);
    mem_bytes = 33'(shadow_pages) << PAGE_BITS;
    fits      = (end_excl <= mem_bytes);
    case (it.kind)
      KIND_LOAD: begin
        if (fits) begin
          for (int k = 0; k < n_bytes; k++)
            res.read_data[8*k +: 8] = byte_at(it.address + k);
          // only byte and word loads honor sign_extend
          if (it.sign_extend && it.size_code == SIZE_B1 && res.read_data[7])
            res.read_data[63:8] = '1;
          if (it.sign_extend && it.size_code == SIZE_B4 && res.read_data[31])
            res.read_data[63:32] = '1;
          res.ok = 1'b1;
        end
      end
      KIND_STORE: begin
        if (fits) begin
          for (int k = 0; k < n_bytes; k++)
            shadow_bytes[it.address + k] = it.write_data[8*k +: 8];
          res.ok = 1'b1;
        end
      end
      KIND_GROW: begin
        page_cap = (shadow_max == 0 || shadow_max > CAP_PAGES) ? CAP_PAGES : shadow_max;
        if (shadow_pages + it.grow_pages <= page_cap) begin
          shadow_pages = shadow_pages + it.grow_pages;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.size_pages = PAGES_W'(shadow_pages);
    return res;
  endfunction

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      shadow_max = 0;
      reload_pages(1);
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: %0h", $time, out_item);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.read_data !== want.read_data)
            report("read_data", want.read_data, out_item.read_data);
          if (out_item.ok !== want.ok)
            report("ok", 64'(want.ok), 64'(out_item.ok));
          if (out_item.size_pages !== want.size_pages)
            report("size_pages", 64'(want.size_pages), 64'(out_item.size_pages));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_INITIAL)
          reload_pages(32'(cfg_wdata));
        else if (cfg_index == REG_MAX)
          shadow_max = 32'(cfg_wdata);
      end
      if (start && !busy)
        pending_results.insert(pending_results.size(), predict_access(in_item));
    end
    outstanding <= pending_results.size();
  end

endmodule

>>> sim/bounds_checked_linear_memory_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the bounds-checked linear memory.
// Depends on bclm_pkg, the block and bclm_memory_check.
module bounds_checked_linear_memory_tb;
  import bclm_pkg::*;

  localparam logic [1:0]  KIND_NOP   = 2'd3;
  localparam logic [1:0]  SIZE_B2    = 2'd1;
  localparam logic [1:0]  SIZE_B8    = 2'd3;
  localparam logic [1:0]  REG_SPARE2 = 2'd2;
  localparam logic [1:0]  REG_SPARE3 = 2'd3;
  localparam int unsigned PAGE_LEN   = 1 << PAGE_BITS;
  localparam int unsigned STORE_SIZE = CAP_PAGES * PAGE_LEN;
  localparam int          CYCLE_LIMIT = 2000000;
  localparam int          N_PHASES   = 8;
  localparam int          PHASE_ITEMS = 160;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [2:0] cfg_wdata;
  int         fail_count;
  int         outstanding;
  int         cycle_count;
  logic       steady;
  int         phase_init [N_PHASES];
  int         phase_max  [N_PHASES];

  bounds_checked_linear_memory u_top (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  bclm_memory_check u_memory_check (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .outstanding
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bounds_checked_linear_memory_tb: done, errors");
      $finish;
    end
  end

  function automatic in_item_t make_access(input logic [1:0] kind, input logic [31:0] addr,
                                           input logic [1:0] size, input logic sext,
                                           input logic [63:0] data, input logic [2:0] grow);
    in_item_t it;
    it.kind        = kind;
    it.address     = addr;
    it.size_code   = size;
    it.sign_extend = sext;
    it.write_data  = data;
    it.grow_pages  = grow;
    return it;
  endfunction

  // Mostly in-range traffic on a few hot spots so loads see earlier stores;
  // the rest straddles page ends, roams the store or lands far out of range.
  function automatic in_item_t random_access();
    in_item_t it;
    int       pick;
    int       where;
    pick  = $urandom_range(99);
    where = $urandom_range(99);
    it.kind = (pick < 42) ? KIND_LOAD : (pick < 84) ? KIND_STORE :
              (pick < 95) ? KIND_GROW : KIND_NOP;
    it.size_code   = 2'($urandom_range(3));
    it.sign_extend = 1'($urandom_range(1));
    it.write_data  = {$urandom, $urandom};
    it.grow_pages  = ($urandom_range(99) < 70) ? 3'($urandom_range(2)) : 3'($urandom_range(7));
    if (where < 55)
      it.address = $urandom_range(3) * PAGE_LEN + $urandom_range(63);
    else if (where < 70)
      it.address = $urandom_range(1, 4) * PAGE_LEN - $urandom_range(1, 12);
    else if (where < 85)
      it.address = $urandom_range(STORE_SIZE - 1);
    else if (where < 93)
      it.address = $urandom;
    else
      it.address = 32'hFFFF_FFFF - $urandom_range(15);
    return it;
  endfunction

  task automatic issue_access(input in_item_t it);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 27)
      gap = $urandom_range(1, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // Hold the sender until every expected result has come, then let the pipe settle.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    cycle_count = 0;
    steady      = 1'b0;
    // a negative initial count skips the reload, leaving the grown size in place
    phase_init  = '{2, 0, 4, 7, -1, 1, 3, 5};
    phase_max   = '{3, 2, 0, 7,  2, 5, 1, 0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // one page, no grow limit beyond capacity
    issue_access(make_access(KIND_LOAD,  32'd0, SIZE_B1, 1'b0, '0, '0));
    issue_access(make_access(KIND_STORE, 32'd5, SIZE_B8, 1'b0, 64'h8877_6655_F433_2281, 3'd7));
    issue_access(make_access(KIND_LOAD,  32'd5, SIZE_B1, 1'b1, '0, '0));
    issue_access(make_access(KIND_LOAD,  32'd5, SIZE_B1, 1'b0, '0, '0));
    issue_access(make_access(KIND_LOAD,  32'd5, SIZE_B4, 1'b1, '0, '0));
    issue_access(make_access(KIND_LOAD,  32'd5, SIZE_B4, 1'b0, '0, '0));
    issue_access(make_access(KIND_LOAD,  32'd8, SIZE_B2, 1'b1, '0, '0));
    issue_access(make_access(KIND_LOAD,  32'd5, SIZE_B8, 1'b1, '0, '0));
    issue_access(make_access(KIND_STORE, PAGE_LEN - 1, SIZE_B1, 1'b1, '1, '0));
    issue_access(make_access(KIND_STORE, PAGE_LEN - 1, SIZE_B2, 1'b0, '1, '0));
    issue_access(make_access(KIND_LOAD,  PAGE_LEN - 8, SIZE_B8, 1'b0, '0, '0));
    issue_access(make_access(KIND_LOAD,  PAGE_LEN - 7, SIZE_B8, 1'b0, '0, '0));
    issue_access(make_access(KIND_LOAD,  32'hFFFF_FFFF, SIZE_B4, 1'b1, '0, '0));
    issue_access(make_access(KIND_STORE, 32'hFFFF_FFFC, SIZE_B8, 1'b1, '1, '0));
    issue_access(make_access(KIND_NOP,   32'hFFFF_FFFF, SIZE_B8, 1'b1, '1, 3'd7));
    issue_access(make_access(KIND_GROW,  32'd0, SIZE_B1, 1'b0, '0, 3'd0));
    issue_access(make_access(KIND_GROW,  32'd0, SIZE_B1, 1'b0, '0, 3'd2));
    issue_access(make_access(KIND_GROW,  32'd0, SIZE_B1, 1'b0, '0, 3'd2));
    issue_access(make_access(KIND_GROW,  32'd0, SIZE_B1, 1'b0, '0, 3'd7));
    issue_access(make_access(KIND_GROW,  32'd0, SIZE_B1, 1'b0, '0, 3'd1));
    issue_access(make_access(KIND_LOAD,  PAGE_LEN, SIZE_B8, 1'b1, '0, '0));
    issue_access(make_access(KIND_STORE, STORE_SIZE - 1, SIZE_B1, 1'b0, 64'h80, '0));
    issue_access(make_access(KIND_LOAD,  STORE_SIZE - 1, SIZE_B1, 1'b1, '0, '0));
    issue_access(make_access(KIND_STORE, STORE_SIZE - 4, SIZE_B8, 1'b0, '1, '0));
    issue_access(make_access(KIND_LOAD,  32'd0, SIZE_B8, 1'b1, '0, '0));
    for (int i = 0; i < PHASE_ITEMS - 10; i++)
      issue_access(random_access());
    drain_results();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 3) begin
        write_reg(REG_SPARE2, 3'h7);
        write_reg(REG_SPARE3, 3'($urandom_range(7)));
      end
      write_reg(REG_MAX, 3'(phase_max[p]));
      if (phase_init[p] >= 0)
        write_reg(REG_INITIAL, 3'(phase_init[p]));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        steady = (p == 2 && i < 120);
        if ($urandom_range(199) == 0)
          drain_results();
        issue_access(random_access());
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("bounds_checked_linear_memory_tb: done, clean");
    else
      $display("bounds_checked_linear_memory_tb: done, errors");
    $finish;
  end

endmodule
